[design/imhq_pkg.sv]
package imhq_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_W    = 32;
  localparam int ID_W     = 8;
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_SLOTS = 1 << ID_W;

  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_POP      = 2'd1,
    OP_DECREASE = 2'd2,
    OP_ERASE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_ABSENT     = 3'd3,
    ST_PRESENT    = 3'd4,
    ST_NOT_SMALLER = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [ID_W-1:0]  item_id;
    logic [KEY_W-1:0] new_key;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [KEY_W-1:0] removed_key;
    logic [ID_W-1:0]  removed_id;
    logic [KEY_W-1:0] top_key;
    logic [ID_W-1:0]  top_id;
    logic             is_empty;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

endpackage

[design/imhq_heap_mem.sv]
module imhq_heap_mem
  import imhq_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [POS_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [POS_W-1:0] raddr_a,
  input  logic [POS_W-1:0] raddr_b,
  output entry_t           rdata_a,
  output entry_t           rdata_b
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[design/imhq_pos_mem.sv]
module imhq_pos_mem
  import imhq_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [ID_W-1:0]  waddr,
  input  logic [POS_W-1:0] wdata,
  input  logic [ID_W-1:0]  raddr,
  output logic [POS_W-1:0] rdata
);

  logic [POS_W-1:0] mem [ID_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/indexed_min_heap_queue_top.sv]
// indexed min-heap of (key, id) entries, one request at a time. the heap lives in a memory
// with two registered read ports and one write port, the id-to-slot table in a second memory.
// the entry being moved is held in a register, and each level of a sift is a read step
// followed by a compare and write-back step. push sifts up; decrease key and erase first
// look up the slot of the id. erase forces the entry up to the root and then removes it
// like a pop, which sifts the last entry down from the root. failed requests answer
// without writing the heap. the heap holds up to 256 entries. a new request is taken once
// the previous one has finished; its response waits in an output register until taken.
module indexed_min_heap_queue_top
  import imhq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DISP     = 12'b0000_0000_0010,
    S_POS      = 12'b0000_0000_0100,
    S_KEY      = 12'b0000_0000_1000,
    S_UP_RD    = 12'b0000_0001_0000,
    S_UP_CMP   = 12'b0000_0010_0000,
    S_POP_RD   = 12'b0000_0100_0000,
    S_POP_LAST = 12'b0000_1000_0000,
    S_DN_RD    = 12'b0001_0000_0000,
    S_DN_CMP   = 12'b0010_0000_0000,
    S_PLACE    = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_t;

  state_t           state;
  logic [1:0]       op;
  logic [ID_W-1:0]  id;
  logic [KEY_W-1:0] key;
  entry_t           mover;
  entry_t           removed;
  entry_t           top;
  logic [POS_W-1:0] p;
  logic [CNT_W-1:0] count;
  logic             force_up;
  status_t          status;
  logic [ID_SLOTS-1:0] present;

  logic             heap_we;
  logic [POS_W-1:0] heap_waddr;
  entry_t           heap_wdata;
  logic [POS_W-1:0] heap_ra;
  logic [POS_W-1:0] heap_rb;
  entry_t           rd_a;
  entry_t           rd_b;
  logic             pos_we;
  logic [ID_W-1:0]  pos_waddr;
  logic [POS_W-1:0] pos_wdata;
  logic [ID_W-1:0]  pos_ra;
  logic [POS_W-1:0] pos_rd;

  logic [POS_W-1:0] p_m1;
  logic [POS_W-1:0] parent;
  logic [CNT_W:0]   lchild;
  logic [CNT_W:0]   rchild;
  logic             up_move;
  logic             lt_l;
  logic [KEY_W-1:0] best_key;
  logic             take_r;
  logic             dn_stay;
  entry_t           child;
  logic [POS_W-1:0] child_pos;
  logic             rsp_load;

  imhq_heap_mem u_heap (
    .clk     (clk),
    .we      (heap_we),
    .waddr   (heap_waddr),
    .wdata   (heap_wdata),
    .raddr_a (heap_ra),
    .raddr_b (heap_rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  imhq_pos_mem u_pos (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_ra),
    .rdata (pos_rd)
  );

  assign req_stall = (state != S_IDLE);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  assign p_m1     = p - POS_W'(1);
  assign parent   = {1'b0, p_m1[POS_W-1:1]};
  assign lchild   = {(CNT_W + 1 - POS_W)'(0), p} + {(CNT_W + 1 - POS_W)'(0), p} + (CNT_W + 1)'(1);
  assign rchild   = lchild + (CNT_W + 1)'(1);
  assign up_move  = force_up || (mover.key < rd_a.key);
  assign lt_l     = rd_a.key < mover.key;
  assign best_key = lt_l ? rd_a.key : mover.key;
  assign take_r   = (rchild < {1'b0, count}) && (rd_b.key < best_key);
  assign dn_stay  = !lt_l && !take_r;
  assign child    = take_r ? rd_b : rd_a;
  assign child_pos = take_r ? rchild[POS_W-1:0] : lchild[POS_W-1:0];

  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = p;
    heap_wdata = mover;
    heap_ra    = '0;
    heap_rb    = '0;
    pos_we     = 1'b0;
    pos_waddr  = mover.id;
    pos_wdata  = p;
    pos_ra     = id;
    unique case (state)
      S_POS: begin
        heap_ra = pos_rd;
      end
      S_UP_RD: begin
        heap_ra = parent;
      end
      S_UP_CMP: begin
        if (up_move) begin
          heap_we    = 1'b1;
          heap_wdata = rd_a;
          pos_we     = 1'b1;
          pos_waddr  = rd_a.id;
        end
      end
      S_POP_RD: begin
        heap_ra = POS_W'(count - CNT_W'(1));
      end
      S_DN_RD: begin
        heap_ra = lchild[POS_W-1:0];
        heap_rb = rchild[POS_W-1:0];
      end
      S_DN_CMP: begin
        if (!dn_stay) begin
          heap_we    = 1'b1;
          heap_wdata = child;
          pos_we     = 1'b1;
          pos_waddr  = child.id;
        end
      end
      S_PLACE: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (heap_we && heap_waddr == '0) begin
      top <= heap_wdata;
    end
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      present   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op       <= req.operation;
            id       <= req.item_id;
            key      <= req.new_key;
            status   <= ST_OK;
            removed  <= '0;
            force_up <= 1'b0;
            state    <= S_DISP;
          end
        end
        S_DISP: begin
          case (op)
            OP_PUSH: begin
              if (count == CNT_W'(CAPACITY)) begin
                status <= ST_FULL;
                state  <= S_DONE;
              end else if (present[id]) begin
                status <= ST_PRESENT;
                state  <= S_DONE;
              end else begin
                mover       <= '{key: key, id: id};
                p           <= count[POS_W-1:0];
                count       <= count + CNT_W'(1);
                present[id] <= 1'b1;
                state       <= S_UP_RD;
              end
            end
            OP_POP: begin
              if (count == '0) begin
                status <= ST_EMPTY;
                state  <= S_DONE;
              end else begin
                removed <= top;
                state   <= S_POP_RD;
              end
            end
            default: begin
              if (!present[id]) begin
                status <= ST_ABSENT;
                state  <= S_DONE;
              end else begin
                state <= S_POS;
              end
            end
          endcase
        end
        S_POS: begin
          p     <= pos_rd;
          state <= S_KEY;
        end
        S_KEY: begin
          if (op == OP_ERASE) begin
            mover    <= rd_a;
            force_up <= 1'b1;
            state    <= S_UP_RD;
          end else if (!(key < rd_a.key)) begin
            status <= ST_NOT_SMALLER;
            state  <= S_DONE;
          end else begin
            mover <= '{key: key, id: id};
            state <= S_UP_RD;
          end
        end
        S_UP_RD: begin
          if (p == '0) begin
            if (force_up) begin
              removed <= mover;
              state   <= S_POP_RD;
            end else begin
              state <= S_PLACE;
            end
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (up_move) begin
            p     <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_PLACE;
          end
        end
        S_POP_RD: begin
          state <= S_POP_LAST;
        end
        S_POP_LAST: begin
          mover               <= rd_a;
          count               <= count - CNT_W'(1);
          present[removed.id] <= 1'b0;
          p                   <= '0;
          state               <= (count == CNT_W'(1)) ? S_DONE : S_DN_RD;
        end
        S_DN_RD: begin
          state <= (lchild >= {1'b0, count}) ? S_PLACE : S_DN_CMP;
        end
        S_DN_CMP: begin
          if (dn_stay) begin
            state <= S_PLACE;
          end else begin
            p     <= child_pos;
            state <= S_DN_RD;
          end
        end
        S_PLACE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status      <= status;
      rsp.removed_key <= removed.key;
      rsp.removed_id  <= removed.id;
      rsp.top_key     <= (count != '0) ? top.key : '0;
      rsp.top_id      <= (count != '0) ? top.id : '0;
      rsp.is_empty    <= (count == '0);
      rsp.entry_count <= count;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == S_POP_LAST |=> count == $past(count) - CNT_W'(1))
    else $error("removal did not shrink the heap");

  a_sink_in_heap: assert property (@(posedge clk) disable iff (rst)
    state == S_DN_CMP |-> {1'b0, p} < count)
    else $error("sift down outside live slots");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.is_empty == (rsp.entry_count == '0))
    else $error("empty flag disagrees with count");

  a_removed_gone: assert property (@(posedge clk) disable iff (rst)
    state == S_POP_LAST |=> !present[$past(removed.id)])
    else $error("removed id still marked present");
`endif

endmodule

[bench/tb_indexed_min_heap_queue_top.sv]
module tb_indexed_min_heap_queue_top;
  import imhq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 232;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  indexed_min_heap_queue_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // heap mirror
  logic [KEY_W-1:0] h_key [CAPACITY];
  logic [ID_W-1:0]  h_id [CAPACITY];
  int               slot_of [ID_SLOTS];
  bit               live [ID_SLOTS];
  int               n_entries;

  rsp_t pending_rsp [$];
  int   n_errors;
  int   idle_cycles;
  int   send_idle_pct;
  int   recv_stall_pct;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t want;
  } row_t;

  function automatic void swap_slots(int a, int b);
    logic [KEY_W-1:0] k;
    logic [ID_W-1:0] d;
    k = h_key[a]; d = h_id[a];
    h_key[a] = h_key[b]; h_id[a] = h_id[b];
    h_key[b] = k; h_id[b] = d;
    slot_of[h_id[a]] = a;
    slot_of[h_id[b]] = b;
  endfunction

  function automatic void sift_up(int p);
    while (p > 0 && h_key[p] < h_key[(p - 1) / 2]) begin
      swap_slots(p, (p - 1) / 2);
      p = (p - 1) / 2;
    end
  endfunction

  function automatic void sift_down(int p);
    int best;
    forever begin
      best = p;
      if (2 * p + 1 < n_entries && h_key[2 * p + 1] < h_key[best]) best = 2 * p + 1;
      if (2 * p + 2 < n_entries && h_key[2 * p + 2] < h_key[best]) best = 2 * p + 2;
      if (best == p) break;
      swap_slots(p, best);
      p = best;
    end
  endfunction

  function automatic rsp_t heap_apply(req_t r);
    rsp_t o;
    o = '0;
    o.status = ST_OK;
    case (op_t'(r.operation))
      OP_PUSH: begin
        if (n_entries >= CAPACITY) o.status = ST_FULL;
        else if (live[r.item_id]) o.status = ST_PRESENT;
        else begin
          h_key[n_entries] = r.new_key;
          h_id[n_entries] = r.item_id;
          slot_of[r.item_id] = n_entries;
          live[r.item_id] = 1'b1;
          n_entries++;
          sift_up(n_entries - 1);
        end
      end
      OP_POP: begin
        if (n_entries == 0) o.status = ST_EMPTY;
      end
      default: begin
        if (!live[r.item_id]) o.status = ST_ABSENT;
        else if (r.operation == OP_DECREASE) begin
          if (!(r.new_key < h_key[slot_of[r.item_id]])) o.status = ST_NOT_SMALLER;
          else begin
            h_key[slot_of[r.item_id]] = r.new_key;
            sift_up(slot_of[r.item_id]);
          end
        end else begin
          for (int p = slot_of[r.item_id]; p > 0; p = (p - 1) / 2) swap_slots(p, (p - 1) / 2);
        end
      end
    endcase
    if (o.status == ST_OK && (r.operation == OP_POP || r.operation == OP_ERASE)) begin
      swap_slots(0, n_entries - 1);
      n_entries--;
      o.removed_key = h_key[n_entries];
      o.removed_id = h_id[n_entries];
      live[h_id[n_entries]] = 1'b0;
      sift_down(0);
    end
    o.top_key = n_entries ? h_key[0] : '0;
    o.top_id = n_entries ? h_id[0] : '0;
    o.is_empty = (n_entries == 0);
    o.entry_count = CNT_W'(n_entries);
    return o;
  endfunction

  task automatic send_request(req_t r, bit typed, rsp_t want);
    rsp_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    p = heap_apply(r);
    if (typed && p !== want) begin
      n_errors++;
      if (n_errors <= 10)
        $display("table row mismatch: table %h predictor %h", want, p);
    end
    pending_rsp.push_back(p);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return '1 - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int tries;
    if ($urandom_range(9) < 8 && n_entries > 0) begin
      for (tries = 0; tries < 64; tries++) begin
        int i;
        i = $urandom_range(ID_SLOTS - 1);
        if (live[i]) return ID_W'(i);
      end
      return h_id[$urandom_range(n_entries - 1)];
    end
    return ID_W'($urandom);
  endfunction

  function automatic req_t random_request();
    req_t r;
    int sel;
    sel = $urandom_range(99);
    r.new_key = pick_key();
    if (sel < 40) begin
      r.operation = OP_PUSH;
      r.item_id = $urandom_range(9) < 8 ? ID_W'($urandom) : pick_id();
    end else if (sel < 60) begin
      r.operation = OP_POP;
      r.item_id = ID_W'($urandom);
    end else if (sel < 82) begin
      r.operation = OP_DECREASE;
      r.item_id = pick_id();
      if (live[r.item_id] && $urandom_range(3) != 0)
        r.new_key = h_key[slot_of[r.item_id]] == 0 ? '0 :
                    $urandom_range(h_key[slot_of[r.item_id]] - 1);
    end else begin
      r.operation = OP_ERASE;
      r.item_id = pick_id();
    end
    return r;
  endfunction

  function automatic rsp_t typed_rsp(status_t s, int cnt);
    rsp_t o;
    o = '0;
    o.status = s;
    o.is_empty = (cnt == 0);
    o.entry_count = CNT_W'(cnt);
    return o;
  endfunction

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected response %h", rsp);
        end else begin
          rsp_t w;
          w = pending_rsp.pop_front();
          if (rsp !== w) begin
            n_errors++;
            if (n_errors <= 10) $display("mismatch: expected %h actual %h", w, rsp);
          end
        end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb_indexed_min_heap_queue_top: errors");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    row_t w;
    req_t r;
    n_errors = 0;
    idle_cycles = 0;
    n_entries = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (live[i]) live[i] = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    w.typed = 1; w.r = '{OP_POP, 8'h00, 32'h0}; w.want = typed_rsp(ST_EMPTY, 0); rows.push_back(w);
    w.r = '{OP_DECREASE, 8'h05, 32'h0}; w.want = typed_rsp(ST_ABSENT, 0); rows.push_back(w);
    w.r = '{OP_ERASE, 8'hff, 32'h0}; w.want = typed_rsp(ST_ABSENT, 0); rows.push_back(w);
    w.r = '{OP_PUSH, 8'hff, 32'hffffffff}; w.want = typed_rsp(ST_OK, 1);
    w.want.top_key = 32'hffffffff; w.want.top_id = 8'hff; rows.push_back(w);
    w.r = '{OP_PUSH, 8'hff, 32'h0}; w.want = typed_rsp(ST_PRESENT, 1);
    w.want.top_key = 32'hffffffff; w.want.top_id = 8'hff; rows.push_back(w);
    w.r = '{OP_DECREASE, 8'hff, 32'hffffffff}; w.want = typed_rsp(ST_NOT_SMALLER, 1);
    w.want.top_key = 32'hffffffff; w.want.top_id = 8'hff; rows.push_back(w);
    w.typed = 0;
    w.r = '{OP_PUSH, 8'h00, 32'h0}; rows.push_back(w);
    w.r = '{OP_PUSH, 8'h01, 32'h0}; rows.push_back(w);
    w.r = '{OP_PUSH, 8'h02, 32'h0}; rows.push_back(w);
    w.r = '{OP_PUSH, 8'haa, 32'h55555555}; rows.push_back(w);
    w.r = '{OP_PUSH, 8'h55, 32'haaaaaaaa}; rows.push_back(w);
    w.r = '{OP_DECREASE, 8'h55, 32'h1}; rows.push_back(w);
    w.r = '{OP_DECREASE, 8'hff, 32'h0}; rows.push_back(w);
    w.r = '{OP_ERASE, 8'haa, 32'h0}; rows.push_back(w);
    w.r = '{OP_POP, 8'h00, 32'h0}; rows.push_back(w);
    w.r = '{OP_ERASE, 8'h02, 32'h0}; rows.push_back(w);
    w.r = '{OP_POP, 8'h00, 32'h0}; rows.push_back(w);
    w.r = '{OP_POP, 8'h00, 32'h0}; rows.push_back(w);
    w.r = '{OP_POP, 8'h00, 32'h0}; rows.push_back(w);
    w.typed = 1; w.r = '{OP_POP, 8'h00, 32'h0}; w.want = typed_rsp(ST_EMPTY, 0); rows.push_back(w);
    foreach (rows[i]) send_request(rows[i].r, rows[i].typed, rows[i].want);
    drain();

    // fill to capacity, then push when full, then send random requests
    send_idle_pct = 7; recv_stall_pct = 7;
    for (int i = 0; i < CAPACITY; i++) begin
      r.operation = OP_PUSH; r.item_id = ID_W'(i); r.new_key = pick_key();
      send_request(r, 0, '0);
    end
    r = '{OP_PUSH, 8'h11, 32'h0};
    send_request(r, 0, '0);
    for (int i = 0; i < 40; i++) send_request(random_request(), 0, '0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 63; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 63; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (int i = 0; i < N_RANDOM / 4; i++) send_request(random_request(), 0, '0);
      drain();
    end

    if (n_errors == 0) $display("tb_indexed_min_heap_queue_top: clean");
    else $display("tb_indexed_min_heap_queue_top: errors");
    $finish;
  end

endmodule
